// ===== rtl/core/oladel_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the ordered list block.
package oladel_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CAP_W  = 9;
	localparam int GROW_W = 8;

	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(10);
	localparam logic [CAP_W-1:0]  CAP_MAX    = {CAP_W{1'b1}};
	localparam logic [GROW_W-1:0] GROW_RESET = GROW_W'(10);

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic req_ready;
		logic latch;
		logic idx_clr;
		logic idx_inc;
		logic rd_next;
		logic shift_we;
		logic append;
		logic rem_done;
		logic fail;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic req_valid;
		logic req_cmd;
		logic cnt_zero;
		logic match;
		logic last_scan;
		logic last_shift;
		logic res_free;
	} ctrl_sts_t;

endpackage

// ===== rtl/core/oladel_if.sv =====
// Channel interfaces: command requests, results and the configuration write port.
interface oladel_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [oladel_pkg::DATA_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

interface oladel_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [oladel_pkg::CNT_W-1:0] item_count;
	logic [oladel_pkg::CAP_W-1:0] capacity;

	modport source (output valid, output ok, output item_count, output capacity, input ready);
	modport sink (input valid, input ok, input item_count, input capacity, output ready);
endinterface

interface oladel_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [oladel_pkg::GROW_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ordered_list_append_delete.sv =====
// Sequencing: an append is accepted, then loads its result once the result register is free; a
// remove reads and compares each entry up to the match, then reads and writes each later entry to
// shift it down, then loads its result. A miss compares every held entry before loading a failed
// result; a remove from an empty list goes straight to loading a failed result. One transaction
// at a time, the next taken once the result is loaded; the single-port entry store with registered
// read sets the scan and shift pace. A new transaction is taken while the previous result waits.
// Reset (arst_n low, asynchronous): count 0, capacity 10, grow step 10; entries are undefined.
module ordered_list_append_delete (
	input logic        clk,
	input logic        arst_n,
	oladel_req_if.sink   req,
	oladel_rsp_if.source rsp,
	oladel_cfg_if.sink   cfg
);
	import oladel_pkg::*;

	ctrl_cmd_t ctl;
	ctrl_sts_t sts;

	oladel_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	oladel_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.ctl    (ctl),
		.sts    (sts)
	);

	// Never overwrite a result that has not been taken
	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.append || ctl.rem_done || ctl.fail) && rsp.valid |-> rsp.ready)
		else $error("result overwritten before transaction");

	// Shift writes and appends never collide
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.shift_we && ctl.append))
		else $error("shift and append write together");

	// Count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.item_count <= CNT_W'(DEPTH))
		else $error("item count beyond depth");

	// Capacity never drops to zero
	a_cap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.capacity != '0)
		else $error("capacity reached zero");

endmodule

// ===== rtl/core/oladel_ctrl.sv =====
// Controller state machine sequencing append, scan, shift and result load.
module oladel_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  oladel_pkg::ctrl_sts_t  sts,
	output oladel_pkg::ctrl_cmd_t  ctl
);
	import oladel_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_APPEND   = 3'd1;
	localparam logic [2:0] ST_SCAN_RD  = 3'd2;
	localparam logic [2:0] ST_SCAN_CMP = 3'd3;
	localparam logic [2:0] ST_SHIFT_RD = 3'd4;
	localparam logic [2:0] ST_SHIFT_WR = 3'd5;
	localparam logic [2:0] ST_REM_DONE = 3'd6;
	localparam logic [2:0] ST_FAIL     = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.req_ready = 1'b1;
				if (sts.req_valid) begin
					ctl.latch   = 1'b1;
					ctl.idx_clr = 1'b1;
					if (sts.req_cmd == CMD_APPEND) begin
						state_d = ST_APPEND;
					end else if (sts.cnt_zero) begin
						state_d = ST_FAIL;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_APPEND: begin
				if (sts.res_free) begin
					ctl.append = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (sts.match) begin
					state_d = sts.last_scan ? ST_REM_DONE : ST_SHIFT_RD;
				end else if (sts.last_scan) begin
					state_d = ST_FAIL;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_SHIFT_RD: begin
				ctl.rd_next = 1'b1;
				state_d     = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				ctl.shift_we = 1'b1;
				ctl.idx_inc  = 1'b1;
				state_d      = sts.last_shift ? ST_REM_DONE : ST_SHIFT_RD;
			end
			ST_REM_DONE: begin
				if (sts.res_free) begin
					ctl.rem_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (sts.res_free) begin
					ctl.fail = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/oladel_dp.sv =====
// Datapath: entry store, count, capacity, grow step register and result register.
module oladel_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	oladel_req_if.sink             req,
	oladel_rsp_if.source           rsp,
	oladel_cfg_if.sink             cfg,
	input  oladel_pkg::ctrl_cmd_t  ctl,
	output oladel_pkg::ctrl_sts_t  sts
);
	import oladel_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] key_q;
	logic [ADDR_W-1:0] idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [CAP_W-1:0]  cap_q;
	logic [GROW_W-1:0] grow_q;
	logic              res_valid_q;
	logic              res_ok_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [CAP_W-1:0]  res_cap_q;

	logic              full;
	logic [ADDR_W-1:0] raddr;
	logic              mem_we;
	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic [CNT_W:0]    idx_p1;
	logic [CNT_W:0]    idx_p2;
	logic [CAP_W:0]    grown;
	logic [CAP_W-1:0]  cap_grow;
	logic [CNT_W-1:0]  cnt_dec;
	logic [CAP_W-1:0]  half;
	logic [CAP_W-1:0]  cap_shrink;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign idx_p1 = (CNT_W + 1)'(idx_q) + (CNT_W + 1)'(1);
	assign idx_p2 = (CNT_W + 1)'(idx_q) + (CNT_W + 1)'(2);

	// Status to controller
	assign sts.req_valid  = req.valid;
	assign sts.req_cmd    = req.cmd;
	assign sts.cnt_zero   = (count_q == '0);
	assign sts.match      = (rdata_q == key_q);
	assign sts.last_scan  = (idx_p1 == {1'b0, count_q});
	assign sts.last_shift = (idx_p2 == {1'b0, count_q});
	assign sts.res_free   = !res_valid_q || rsp.ready;

	assign req.ready = ctl.req_ready;
	assign cfg.ready = 1'b1;

	// Grow rule: when the count equals the capacity, add the grow step, saturating at the largest capacity code
	always_comb begin
		grown    = {1'b0, cap_q} + (CAP_W + 1)'(grow_q);
		cap_grow = grown[CAP_W] ? CAP_MAX : grown[CAP_W-1:0];
		if (CAP_W'(count_q) == cap_q) begin
			cap_grow = grown[CAP_W] ? CAP_MAX : grown[CAP_W-1:0];
		end else begin
			cap_grow = cap_q;
		end
	end

	// Shrink rule after a removal
	always_comb begin
		cnt_dec    = count_q - CNT_W'(1);
		half       = cap_q >> 1;
		cap_shrink = cap_q;
		if ((CAP_W'(cnt_dec) < half) && ((cap_q - half) >= CAP_W'(1))) begin
			cap_shrink = cap_q - half;
		end
	end

	// Store port selection
	assign raddr  = ctl.rd_next ? idx_p1[ADDR_W-1:0] : idx_q;
	assign mem_we = ctl.shift_we || (ctl.append && !full);
	assign waddr  = ctl.shift_we ? idx_q : count_q[ADDR_W-1:0];
	assign wdata  = ctl.shift_we ? rdata_q : key_q;

	// Entry store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			key_q <= req.value;
		end
	end

	// Advance scan and shift index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.idx_clr) begin
			idx_q <= '0;
		end else if (ctl.idx_inc) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
	end

	// Count, capacity and grow step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			grow_q  <= GROW_RESET;
		end else begin
			if (cfg.valid) begin
				grow_q <= cfg.data;
			end
			if (ctl.append && !full) begin
				count_q <= count_q + CNT_W'(1);
				cap_q   <= cap_grow;
			end else if (ctl.rem_done) begin
				count_q <= cnt_dec;
				cap_q   <= cap_shrink;
			end
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.append || ctl.rem_done || ctl.fail) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.append) begin
			res_ok_q  <= !full;
			res_cnt_q <= full ? count_q : count_q + CNT_W'(1);
			res_cap_q <= full ? cap_q : cap_grow;
		end else if (ctl.rem_done) begin
			res_ok_q  <= 1'b1;
			res_cnt_q <= cnt_dec;
			res_cap_q <= cap_shrink;
		end else if (ctl.fail) begin
			res_ok_q  <= 1'b0;
			res_cnt_q <= count_q;
			res_cap_q <= cap_q;
		end
	end

	assign rsp.valid      = res_valid_q;
	assign rsp.ok         = res_ok_q;
	assign rsp.item_count = res_cnt_q;
	assign rsp.capacity   = res_cap_q;

endmodule

// ===== tb/ordered_list_append_delete_test.sv =====
// Self-checking testbench for the ordered list block: random commands against a predictor.
module ordered_list_append_delete_test;
	import oladel_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 170;

	typedef struct packed {
		logic              op;
		logic [DATA_W-1:0] value;
	} list_cmd_t;

	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] item_count;
		logic [CAP_W-1:0] capacity;
	} list_status_t;

	typedef enum {FILL_WAVE, DRAIN_WAVE, MIXED_WAVE} wave_kind_t;
	typedef enum {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_BLOCKS} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	oladel_req_if req_ch();
	oladel_rsp_if rsp_ch();
	oladel_cfg_if cfg_ch();

	ordered_list_append_delete dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predicted list contents, count, capacity and grow step
	logic [DATA_W-1:0] held [DEPTH];
	logic [CNT_W-1:0]  held_count;
	logic [CAP_W-1:0]  nominal_cap;
	logic [GROW_W-1:0] grow_amt;

	list_cmd_t    command_queue [$];
	list_status_t awaited_status [$];
	logic [DATA_W-1:0] shadow_values [$];

	int items_queued = 0;
	int failures     = 0;
	int cycle_count  = 0;
	int n_appends    = 0;
	int n_removes    = 0;
	int n_full       = 0;
	int n_misses     = 0;
	int n_grows      = 0;
	int n_shrinks    = 0;
	int n_settings   = 1;

	int burst_left = 1;
	int gap_left   = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_mode_left = 100;
	int rx_off_left  = 0;
	logic rx_next;
	list_status_t got;
	list_status_t want;

	always #10 clk = ~clk;

	// Apply one accepted command to the predicted list and queue the status it returns
	task automatic apply_list_command(input logic op, input logic [DATA_W-1:0] v);
		list_status_t res;
		int hit;
		int half;
		int grown;
		hit = -1;
		res.ok = 1'b0;
		if (op == CMD_APPEND) begin
			n_appends++;
			if (held_count < DEPTH) begin
				if (held_count == nominal_cap) begin
					grown = int'(nominal_cap) + int'(grow_amt);
					nominal_cap = (grown > int'(CAP_MAX)) ? CAP_MAX : CAP_W'(grown);
					n_grows++;
				end
				held[held_count] = v;
				held_count++;
				res.ok = 1'b1;
			end else begin
				n_full++;
			end
		end else begin
			n_removes++;
			for (int i = 0; i < held_count; i++) begin
				if (hit < 0 && held[i] == v)
					hit = i;
			end
			if (hit >= 0) begin
				for (int j = hit; j + 1 < held_count; j++)
					held[j] = held[j + 1];
				held_count--;
				half = nominal_cap / 2;
				if (held_count < half && int'(nominal_cap) - half >= 1) begin
					nominal_cap = nominal_cap - CAP_W'(half);
					n_shrinks++;
				end
				res.ok = 1'b1;
			end else begin
				n_misses++;
			end
		end
		res.item_count = held_count;
		res.capacity = nominal_cap;
		awaited_status.push_back(res);
	endtask

	// Queue a command and track the list contents it leaves behind
	task automatic queue_command(input logic op, input logic [DATA_W-1:0] v);
		int hit;
		list_cmd_t c;
		hit = -1;
		c.op = op;
		c.value = v;
		command_queue.push_back(c);
		items_queued++;
		if (op == CMD_APPEND) begin
			if (shadow_values.size() < DEPTH)
				shadow_values.push_back(v);
		end else begin
			foreach (shadow_values[i]) begin
				if (hit < 0 && shadow_values[i] == v)
					hit = i;
			end
			if (hit >= 0)
				shadow_values.delete(hit);
		end
	endtask

	// In three draws of ten a small value from -8 to 7 so duplicates occur, otherwise a full-range value
	function automatic logic [DATA_W-1:0] draw_value();
		if ($urandom_range(0, 9) < 3)
			return DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
		return DATA_W'($urandom());
	endfunction

	function automatic logic [DATA_W-1:0] held_value();
		if (shadow_values.size() == 0)
			return draw_value();
		return shadow_values[$urandom_range(0, shadow_values.size() - 1)];
	endfunction

	task automatic queue_wave(input wave_kind_t kind);
		int r;
		case (kind)
			FILL_WAVE: begin
				// fill to the store limit, then knock on it a few times
				while (shadow_values.size() < DEPTH) begin
					if (shadow_values.size() == 0 || $urandom_range(0, 99) < 85)
						queue_command(CMD_APPEND, draw_value());
					else
						queue_command(CMD_REMOVE, held_value());
				end
				repeat ($urandom_range(1, 5)) queue_command(CMD_APPEND, draw_value());
			end
			DRAIN_WAVE: begin
				// empty the list so the capacity shrinks, then remove from empty
				while (shadow_values.size() > 0) begin
					r = $urandom_range(0, 9);
					if (r < 8)
						queue_command(CMD_REMOVE, held_value());
					else if (r == 8)
						queue_command(CMD_REMOVE, draw_value());
					else
						queue_command(CMD_APPEND, draw_value());
				end
				repeat ($urandom_range(1, 3)) queue_command(CMD_REMOVE, draw_value());
			end
			default: begin
				repeat ($urandom_range(10, 40)) begin
					r = $urandom_range(0, 9);
					if (r < 5)
						queue_command(CMD_APPEND, draw_value());
					else if (r < 9)
						queue_command(CMD_REMOVE, held_value());
					else
						queue_command(CMD_REMOVE, draw_value());
				end
			end
		endcase
	endtask

	task automatic wait_idle();
		while (command_queue.size() != 0 || awaited_status.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_grow_step(input logic [GROW_W-1:0] step);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= step;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		grow_amt = step;
		n_settings++;
	endtask

	// Drive commands in bursts with random gaps; predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= CMD_APPEND;
			req_ch.value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				apply_list_command(req_ch.cmd, req_ch.value);
				void'(command_queue.pop_front());
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (command_queue.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.cmd <= command_queue[0].op;
					req_ch.value <= command_queue[0].value;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
							: $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Check each result transaction and stall the result channel on a changing pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.ok = rsp_ch.ok;
				got.item_count = rsp_ch.item_count;
				got.capacity = rsp_ch.capacity;
				if (awaited_status.size() == 0) begin
					$error("result with none expected: ok %0d item_count %0d capacity %0d",
						got.ok, got.item_count, got.capacity);
					failures++;
				end else begin
					want = awaited_status.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						failures++;
					end
					if (got.item_count !== want.item_count) begin
						$error("item_count: expected %0d, got %0d", want.item_count,
							got.item_count);
						failures++;
					end
					if (got.capacity !== want.capacity) begin
						$error("capacity: expected %0d, got %0d", want.capacity, got.capacity);
						failures++;
					end
				end
			end
			if (rx_mode_left > 0) begin
				rx_mode_left--;
			end else begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(50, 300);
			end
			case (rx_mode)
				RX_OPEN: rx_next = 1'b1;
				RX_ALTERNATE: rx_next = ~rsp_ch.ready;
				RX_RANDOM: rx_next = $urandom_range(0, 9) < 7;
				default: begin
					if (rx_off_left > 0) begin
						rx_off_left--;
						rx_next = 1'b0;
					end else begin
						if ($urandom_range(0, 7) == 0)
							rx_off_left = $urandom_range(1, 20);
						rx_next = 1'b1;
					end
				end
			endcase
			rsp_ch.ready <= rx_next;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int phase_start;
		logic [GROW_W-1:0] step;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		held_count = '0;
		nominal_cap = CAP_RESET;
		grow_amt = GROW_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// remove from an empty list
		queue_command(CMD_REMOVE, 32'h0000_0000);
		// extreme and all-ones/all-zeros values, plus a duplicate pair
		queue_command(CMD_APPEND, 32'h8000_0000);
		queue_command(CMD_APPEND, 32'h7FFF_FFFF);
		queue_command(CMD_APPEND, 32'hFFFF_FFFF);
		queue_command(CMD_APPEND, 32'h0000_0000);
		queue_command(CMD_APPEND, 32'h0000_0005);
		queue_command(CMD_APPEND, 32'h0000_0005);
		// first of two equal entries, a middle entry, a miss, the head, the tail
		queue_command(CMD_REMOVE, 32'h0000_0005);
		queue_command(CMD_REMOVE, 32'h7FFF_FFFF);
		queue_command(CMD_REMOVE, 32'h0000_1234);
		queue_command(CMD_REMOVE, 32'h8000_0000);
		queue_command(CMD_REMOVE, 32'h0000_0005);
		// append past the shrunken capacity so it grows
		for (int k = 0; k < 10; k++)
			queue_command(CMD_APPEND, DATA_W'(100 + k));
		queue_command(CMD_REMOVE, 32'h0000_0064);
		queue_command(CMD_REMOVE, 32'hFFFF_FFFF);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				case (p)
					1, 7: step = 8'd1;
					2, 8: step = 8'd255;
					3: step = 8'd0;
					default: step = GROW_W'($urandom_range(2, 254));
				endcase
				wait_idle();
				write_grow_step(step);
				@(negedge clk);
			end
			phase_start = items_queued;
			while (items_queued - phase_start < PHASE_ITEMS)
				queue_wave(wave_kind_t'($urandom_range(0, 2)));
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("%0d list commands: %0d appends, %0d removes, %0d rejected as full, %0d misses",
			n_appends + n_removes, n_appends, n_removes, n_full, n_misses);
		$display("%0d capacity grows and %0d shrinks over %0d grow-step settings",
			n_grows, n_shrinks, n_settings);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
